### rtl/cvls_pkg.sv
package cvls_pkg;

  localparam int CAPACITY = 64;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 16;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 7;

  // Derived widths
  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int SUM_W   = VAL_W + CNT_W;
  localparam int DSTEP_W = $clog2(SUM_W);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_REPORT = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    wr_append;
    logic    wr_update;
    logic    wr_shift;
    logic    rd_shift;
    logic    rd_sum;
    logic    ptr_load_idx;
    logic    ptr_clr;
    logic    fill_dec;
    logic    acc_clr;
    logic    div_start;
    logic    load_out;
    logic    out_stats;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic bad_idx;
    logic shift_more;
    logic rd_more;
    logic div_done;
  } dp_sts_t;

endpackage

### rtl/cvls_div.sv
module cvls_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cvls_pkg::SUM_W-1:0]  dividend,
  input  logic [cvls_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [cvls_pkg::SUM_W-1:0]  quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [cvls_pkg::DSTEP_W-1:0]  step_r;
  logic [cvls_pkg::SUM_W-1:0]    q_r;
  logic [cvls_pkg::CNT_W-1:0]    rem_r;
  logic [cvls_pkg::CNT_W-1:0]    dvs_r;

  logic [cvls_pkg::CNT_W:0]      trial;
  logic                          fits;
  logic [cvls_pkg::CNT_W:0]      diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, q_r[cvls_pkg::SUM_W-1]};
    fits  = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
      step_r <= cvls_pkg::DSTEP_W'(cvls_pkg::SUM_W - 1);
    end else if (busy_r) begin
      q_r    <= {q_r[cvls_pkg::SUM_W-2:0], fits};
      rem_r  <= fits ? diff[cvls_pkg::CNT_W-1:0] : trial[cvls_pkg::CNT_W-1:0];
      step_r <= step_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/cvls_dp.sv
module cvls_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cvls_pkg::dp_cmd_t                 cmd,
  output cvls_pkg::dp_sts_t                 sts,
  input  logic [cvls_pkg::OP_W-1:0]         in_operation,
  input  logic [cvls_pkg::IDX_W-1:0]        in_index,
  input  logic signed [cvls_pkg::VAL_W-1:0] in_value,
  output logic [cvls_pkg::ST_W-1:0]         out_status,
  output logic [cvls_pkg::COUNT_W-1:0]      out_count,
  output logic signed [cvls_pkg::VAL_W-1:0] out_mean,
  output logic signed [cvls_pkg::VAL_W-1:0] out_largest,
  output logic signed [cvls_pkg::VAL_W-1:0] out_smallest
);

  localparam int ADDR_W = cvls_pkg::ADDR_W;
  localparam int CNT_W  = cvls_pkg::CNT_W;
  localparam int CMP_W  = cvls_pkg::CMP_W;
  localparam int SUM_W  = cvls_pkg::SUM_W;
  localparam int VAL_W  = cvls_pkg::VAL_W;

  logic [VAL_W-1:0]         mem [cvls_pkg::CAPACITY];

  cvls_pkg::op_t            op_r;
  logic [cvls_pkg::IDX_W-1:0] idx_r;
  logic [VAL_W-1:0]         val_r;
  logic [CNT_W-1:0]         fill_r;
  logic [CNT_W-1:0]         ptr_r;
  logic signed [VAL_W-1:0]  rdata_r;
  logic                     rv_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [VAL_W-1:0]  max_r;
  logic signed [VAL_W-1:0]  min_r;
  logic                     neg_r;

  logic [cvls_pkg::ST_W-1:0]    out_status_r;
  logic [cvls_pkg::COUNT_W-1:0] out_count_r;
  logic signed [VAL_W-1:0]      out_mean_r;
  logic signed [VAL_W-1:0]      out_largest_r;
  logic signed [VAL_W-1:0]      out_smallest_r;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [VAL_W-1:0]         wr_data;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic [CNT_W:0]           ptr_p1;
  logic [SUM_W-1:0]         sum_mag;
  logic                     div_done;
  logic [SUM_W-1:0]         quot;
  logic [VAL_W-1:0]         mean_res;

  assign ptr_p1 = {1'b0, ptr_r} + 1'b1;

  always_comb begin
    sts.op         = op_r;
    sts.empty      = (fill_r == '0);
    sts.full       = (fill_r == CNT_W'(cvls_pkg::CAPACITY));
    sts.bad_idx    = (CMP_W'(idx_r) >= CMP_W'(fill_r));
    sts.shift_more = (ptr_p1 < {1'b0, fill_r});
    sts.rd_more    = (ptr_r < fill_r);
    sts.div_done   = div_done;
  end

  // single write port, single registered read port
  always_comb begin
    wr_en   = cmd.wr_append | cmd.wr_update | cmd.wr_shift;
    wr_addr = ADDR_W'(ptr_r);
    wr_data = rdata_r;
    if (cmd.wr_append) begin
      wr_addr = ADDR_W'(fill_r);
      wr_data = val_r;
    end else if (cmd.wr_update) begin
      wr_addr = ADDR_W'(idx_r);
      wr_data = val_r;
    end
    rd_en   = cmd.rd_shift | cmd.rd_sum;
    rd_addr = cmd.rd_shift ? ADDR_W'(ptr_p1) : ADDR_W'(ptr_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rv_r   <= 1'b0;
    end else begin
      rv_r <= cmd.rd_sum;
      if (cmd.wr_append) begin
        fill_r <= fill_r + 1'b1;
      end else if (cmd.fill_dec) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= cvls_pkg::op_t'(in_operation);
      idx_r <= in_index;
      val_r <= in_value;
    end
    if (cmd.ptr_load_idx) begin
      ptr_r <= CNT_W'(idx_r);
    end else if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.wr_shift || cmd.rd_sum) begin
      ptr_r <= ptr_r + 1'b1;
    end
    if (cmd.acc_clr) begin
      sum_r <= '0;
      max_r <= {1'b1, {(VAL_W-1){1'b0}}};
      min_r <= {1'b0, {(VAL_W-1){1'b1}}};
    end else if (rv_r) begin
      sum_r <= sum_r + {{(SUM_W-VAL_W){rdata_r[VAL_W-1]}}, rdata_r};
      if (rdata_r > max_r) max_r <= rdata_r;
      if (rdata_r < min_r) min_r <= rdata_r;
    end
    if (cmd.div_start) begin
      neg_r <= sum_r[SUM_W-1];
    end
  end

  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  cvls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (quot)
  );

  // quotient truncates toward zero; restore the sign
  assign mean_res = neg_r ? VAL_W'(-quot[VAL_W-1:0]) : quot[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r   <= cmd.status;
      out_count_r    <= (cvls_pkg::COUNT_W)'(fill_r);
      out_mean_r     <= cmd.out_stats ? mean_res : '0;
      out_largest_r  <= cmd.out_stats ? max_r : '0;
      out_smallest_r <= cmd.out_stats ? min_r : '0;
    end
  end

  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_mean     = out_mean_r;
  assign out_largest  = out_largest_r;
  assign out_smallest = out_smallest_r;

`ifndef NO_ASSERTIONS
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_append, cmd.wr_update, cmd.wr_shift}))
    else $error("more than one memory write source");

  a_one_reader: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_shift && cmd.rd_sum))
    else $error("shift and sum reads collide");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(cvls_pkg::CAPACITY))
    else $error("fill count beyond capacity");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_append |-> !sts.full)
    else $error("append written into a full list");

  a_no_wr_past_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_update || cmd.wr_shift) |-> (CMP_W'(wr_addr) < CMP_W'(fill_r)))
    else $error("write beyond stored entries");
`endif

endmodule

### rtl/cvls_ctrl.sv
module cvls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cvls_pkg::dp_sts_t sts,
  output cvls_pkg::dp_cmd_t cmd
);

  cvls_pkg::state_t  state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  cvls_pkg::status_t st_r, st_nxt;
  logic              stats_r, stats_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cvls_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_nxt;
    stats_r <= stats_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    st_nxt        = st_r;
    stats_nxt     = stats_r;
    cmd           = '0;
    cmd.status    = st_r;
    cmd.out_stats = stats_r;

    case (state_r)
      cvls_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = cvls_pkg::S_EXEC;
        end
      end
      cvls_pkg::S_EXEC: begin
        stats_nxt = 1'b0;
        state_nxt = cvls_pkg::S_OUT;
        st_nxt    = cvls_pkg::ST_OK;
        case (sts.op)
          cvls_pkg::OP_APPEND: begin
            if (sts.full) begin
              st_nxt = cvls_pkg::ST_FULL;
            end else begin
              cmd.wr_append = 1'b1;
            end
          end
          cvls_pkg::OP_UPDATE: begin
            if (sts.empty) begin
              st_nxt = cvls_pkg::ST_EMPTY;
            end else if (sts.bad_idx) begin
              st_nxt = cvls_pkg::ST_INDEX;
            end else begin
              cmd.wr_update = 1'b1;
            end
          end
          cvls_pkg::OP_REMOVE: begin
            if (sts.empty) begin
              st_nxt = cvls_pkg::ST_EMPTY;
            end else if (sts.bad_idx) begin
              st_nxt = cvls_pkg::ST_INDEX;
            end else begin
              cmd.ptr_load_idx = 1'b1;
              state_nxt        = cvls_pkg::S_SHIFT_CHK;
            end
          end
          default: begin
            if (sts.empty) begin
              st_nxt = cvls_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_clr = 1'b1;
              cmd.acc_clr = 1'b1;
              state_nxt   = cvls_pkg::S_SUM;
            end
          end
        endcase
      end
      cvls_pkg::S_SHIFT_CHK: begin
        if (sts.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = cvls_pkg::S_SHIFT_WR;
        end else begin
          cmd.fill_dec = 1'b1;
          state_nxt    = cvls_pkg::S_OUT;
        end
      end
      cvls_pkg::S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = cvls_pkg::S_SHIFT_CHK;
      end
      cvls_pkg::S_SUM: begin
        // last read data is accumulated on the edge leaving this state
        if (sts.rd_more) begin
          cmd.rd_sum = 1'b1;
        end else begin
          state_nxt = cvls_pkg::S_DIV_GO;
        end
      end
      cvls_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = cvls_pkg::S_DIV_WAIT;
      end
      cvls_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          st_nxt    = cvls_pkg::ST_OK;
          stats_nxt = 1'b1;
          state_nxt = cvls_pkg::S_OUT;
        end
      end
      cvls_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cvls_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cvls_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == cvls_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/compacting_value_list_stats_top.sv
// Bounded list of up to CAPACITY (64) signed 16-bit values in hundredths,
// kept packed from position 0. Each input transaction carries one operation:
// append, remove at index (later entries shift down), update at index, or
// report; each yields exactly one result transaction with status, the count
// after the operation and, on a successful report, mean (truncated toward
// zero), largest and smallest, else zeros. A remove moves each entry above
// the removed one down with one memory read and one write per moved entry;
// a report walks the value memory one entry per cycle and then runs a
// 23-step bit-serial divider. A new transaction is taken as soon as the
// previous one has finished, even while its result still sits in the output
// register; the block holds off the next result only until that one is taken.
// No clearing pass is needed after reset.
module compacting_value_list_stats_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cvls_pkg::OP_W-1:0]         in_operation,
  input  logic [cvls_pkg::IDX_W-1:0]        in_index,
  input  logic signed [cvls_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cvls_pkg::ST_W-1:0]         out_status,
  output logic [cvls_pkg::COUNT_W-1:0]      out_count,
  output logic signed [cvls_pkg::VAL_W-1:0] out_mean,
  output logic signed [cvls_pkg::VAL_W-1:0] out_largest,
  output logic signed [cvls_pkg::VAL_W-1:0] out_smallest
);

  // controller <-> datapath
  cvls_pkg::dp_cmd_t cmd;
  cvls_pkg::dp_sts_t sts;

  // sequencer: decode, shift loop, stats walk, divide, result handoff
  cvls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // value memory, fill count, accumulators, divider, result register
  cvls_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_operation),
    .in_index     (in_index),
    .in_value     (in_value),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_mean     (out_mean),
    .out_largest  (out_largest),
    .out_smallest (out_smallest)
  );

endmodule
